/* hdl/fir_eh_pkg.sv */
// Shared types and constants for the edge-hold FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package fir_eh_pkg;

	localparam int unsigned TAP_COUNT_W   = 7;
	localparam int unsigned COEF_INDEX_W  = 6;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

	// func codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_FILTER = 1'b1;

	// per-cycle control from the handshake logic to the tap lanes
	typedef struct packed {
		logic advance;  // whole pipeline moves this cycle
		logic load;     // coefficient load beat accepted
		logic filter;   // sample beat accepted
		logic fill;     // sample beat fills the whole delay line
	} tap_ctrl_t;

endpackage

`default_nettype wire

/* hdl/fir_eh_taps.sv */
// Delay line, coefficient registers and registered per-tap products.
`timescale 1ns / 1ps
`default_nettype none

module fir_eh_taps
	import fir_eh_pkg::*;
#(
	parameter int unsigned TAPS        = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned COEF_BITS   = 18
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  tap_ctrl_t                                    ctrl,
	input  logic        [TAP_COUNT_W-1:0]                tap_count,
	input  logic        [COEF_INDEX_W-1:0]               coef_index,
	input  logic signed [COEF_BITS-1:0]                  coef_value,
	input  logic signed [SAMPLE_BITS-1:0]                sample_in,
	output logic signed [SAMPLE_BITS+COEF_BITS-1:0]      prod_s1 [TAPS]
);

	localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;

	logic signed [SAMPLE_BITS-1:0] delay_q [TAPS];
	logic signed [COEF_BITS-1:0]   coef_q  [TAPS];

	for (genvar k = 0; k < TAPS; k++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				delay_q[k] <= '0;
			end else if (ctrl.filter) begin
				if (ctrl.fill || k == 0) begin
					delay_q[k] <= sample_in;
				end else begin
					delay_q[k] <= delay_q[(k == 0) ? 0 : k - 1];
				end
			end
		end

		// indices at or beyond TAPS match no lane and are dropped
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_q[k] <= '0;
			end else if (ctrl.load && 32'(coef_index) == k) begin
				coef_q[k] <= coef_value;
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.advance) begin
				if (32'(k) < 32'(tap_count)) begin
					prod_s1[k] <= PROD_W'(delay_q[k] * coef_q[k]);
				end else begin
					prod_s1[k] <= '0;
				end
			end
		end
	end

	a_fill_spreads : assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.filter && ctrl.fill |=> delay_q[TAPS-1] == delay_q[0])
		else $error("fill did not reach the end of the delay line");

	a_load_first : assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load && coef_index == '0 |=> coef_q[0] == $past(coef_value))
		else $error("coefficient load at index zero lost");

endmodule

`default_nettype wire

/* hdl/fir_eh_tree.sv */
// Pipelined binary adder tree, one register level per tree level.
`timescale 1ns / 1ps
`default_nettype none

module fir_eh_tree #(
	parameter int unsigned TAPS   = 64,
	parameter int unsigned PROD_W = 34,
	parameter int unsigned ACC_W  = 40
) (
	input  logic                     clk,
	input  logic                     advance,
	input  logic signed [PROD_W-1:0] prod [TAPS],
	output logic signed [ACC_W-1:0]  sum
);

	localparam int unsigned LEVELS = $clog2(TAPS);
	localparam int unsigned NP     = 1 << LEVELS;

	logic signed [ACC_W-1:0] leaf   [NP];
	logic signed [ACC_W-1:0] node_q [1:NP-1];

	for (genvar j = 0; j < NP; j++) begin : g_leaf
		if (j < TAPS) begin : g_used
			assign leaf[j] = ACC_W'(prod[j]);
		end else begin : g_pad
			assign leaf[j] = '0;
		end
	end

	// heap layout: node i adds children 2i and 2i+1, leaves sit at NP..2NP-1
	for (genvar i = 1; i < NP; i++) begin : g_node
		if (2 * i >= NP) begin : g_bottom
			always_ff @(posedge clk) begin
				if (advance) begin
					node_q[i] <= leaf[2*i-NP] + leaf[2*i+1-NP];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (advance) begin
					node_q[i] <= node_q[2*i] + node_q[2*i+1];
				end
			end
		end
	end

	assign sum = node_q[1];

endmodule

`default_nettype wire

/* hdl/fir_eh_round.sv */
// Round-half-up from fixed point, saturate, and hold the result register.
`timescale 1ns / 1ps
`default_nettype none

module fir_eh_round #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned FRAC_BITS   = 16,
	parameter int unsigned ACC_W       = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic signed [ACC_W-1:0]       sum,
	output logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic                          sat_q
);

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]       HALF = ACC_W'(1) << (FRAC_BITS - 1);

	logic signed [ACC_W-1:0] rounded;
	logic signed [ACC_W-1:0] scaled;
	logic                    fits;

	assign rounded = sum + HALF;
	assign scaled  = rounded >>> FRAC_BITS;
	// fits when every bit above the sample sign bit copies it
	assign fits = (&scaled[ACC_W-1:SAMPLE_BITS-1]) || !(|scaled[ACC_W-1:SAMPLE_BITS-1]);

	always_ff @(posedge clk) begin
		if (advance) begin
			sat_q <= !fits;
			if (fits) begin
				sample_q <= scaled[SAMPLE_BITS-1:0];
			end else if (scaled[ACC_W-1]) begin
				sample_q <= SMIN;
			end else begin
				sample_q <= SMAX;
			end
		end
	end

	a_sat_rails : assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> (sample_q == SMAX || sample_q == SMIN))
		else $error("saturation flag without a rail value");

endmodule

`default_nettype wire

/* hdl/fir_filter_edge_hold.sv */
// Top level of the edge-hold direct-form FIR filter.
// Usage:
//   s_axis carries load beats (func = 0: coefficient index and value) and
//   sample beats (func = 1: sample, first-of-signal flag). A first-of-signal
//   beat fills the whole delay line with its sample before filtering.
//   m_axis returns one filtered, rounded, saturated sample per sample beat;
//   load beats produce nothing. cfg_we/cfg_data set tap_count while idle.
// Timing:
//   One beat per cycle sustained while m_axis takes results. A result
//   passes through the delay-line register, the product register, one
//   register per adder-tree level, and the output register.
// Reset:
//   arst_n clears delay line and coefficients to zero, tap_count to 64,
//   and empties the pipeline.
// Stall:
//   With a result waiting and m_axis_tready low, the whole pipeline holds and
//   s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_edge_hold
	import fir_eh_pkg::*;
#(
	parameter int unsigned TAPS        = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned COEF_BITS   = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [TAP_COUNT_W-1:0]                cfg_data,   // tap_count
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// coef_index, coef_value, sample_in, zero pad
	input  logic [((COEF_INDEX_W+COEF_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic [1:0]                            s_axis_tuser, // func, first_of_signal
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata, // sample_out, zero pad
	output logic [0:0]                            m_axis_tuser  // saturated
);

	localparam int unsigned LEVELS = $clog2(TAPS);
	localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int unsigned ACC_W  = PROD_W + LEVELS;
	localparam int unsigned PIPE   = LEVELS + 2;
	localparam int unsigned OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int unsigned VAL_LO = COEF_INDEX_W;
	localparam int unsigned SMP_LO = COEF_INDEX_W + COEF_BITS;

	logic [TAP_COUNT_W-1:0]            tap_count_q;
	tap_ctrl_t                         ctrl;
	logic                              accept;
	logic                              out_valid_q;
	logic [PIPE-1:0]                   valid_q;
	logic signed [PROD_W-1:0]          prod_s1 [TAPS];
	logic signed [ACC_W-1:0]           sum;
	logic signed [SAMPLE_BITS-1:0]     sample_q;
	logic                              sat_q;
	logic [COEF_INDEX_W-1:0]           coef_index;
	logic signed [COEF_BITS-1:0]       coef_value;
	logic signed [SAMPLE_BITS-1:0]     sample_in;

	assign coef_index = s_axis_tdata[COEF_INDEX_W-1:0];
	assign coef_value = s_axis_tdata[VAL_LO +: COEF_BITS];
	assign sample_in  = s_axis_tdata[SMP_LO +: SAMPLE_BITS];

	assign ctrl.advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = ctrl.advance;
	assign accept        = s_axis_tvalid && ctrl.advance;
	assign ctrl.load     = accept && s_axis_tuser[0] == FUNC_LOAD;
	assign ctrl.filter   = accept && s_axis_tuser[0] == FUNC_FILTER;
	assign ctrl.fill     = s_axis_tuser[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (cfg_we) begin
			tap_count_q <= cfg_data;
		end
	end

	// valid_q[0]: sample in delay line, then products, then each tree level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (ctrl.advance) begin
			valid_q     <= PIPE'({valid_q, ctrl.filter});
			out_valid_q <= valid_q[PIPE-1];
		end
	end

	fir_eh_taps #(
		.TAPS        (TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_taps (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.tap_count  (tap_count_q),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.sample_in  (sample_in),
		.prod_s1    (prod_s1)
	);

	fir_eh_tree #(
		.TAPS   (TAPS),
		.PROD_W (PROD_W),
		.ACC_W  (ACC_W)
	) u_tree (
		.clk     (clk),
		.advance (ctrl.advance),
		.prod    (prod_s1),
		.sum     (sum)
	);

	fir_eh_round #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (COEF_BITS - 2),
		.ACC_W       (ACC_W)
	) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (ctrl.advance),
		.sum      (sum),
		.sample_q (sample_q),
		.sat_q    (sat_q)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({{(OUT_W-SAMPLE_BITS){1'b0}}, sample_q});
	assign m_axis_tuser  = sat_q;

	a_out_from_chain : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_q[PIPE-1]))
		else $error("result beat without a sample in the pipeline");

	a_load_no_result : assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> !valid_q[0])
		else $error("load beat entered the result pipeline");

endmodule

`default_nettype wire
